/* rtl/oks_pkg.sv */
// Shared types, keyword tables and constants of the option keyword scanner.
package oks_pkg;

   localparam int KwCount    = 16;
   localparam int KwMax      = 18;
   localparam int MaskWidth  = 15;
   localparam int PosWidth   = 5;
   localparam int QueueDepth = 4;

   typedef enum logic [2:0] {
      CLS_NUL   = 3'd0,
      CLS_BLANK = 3'd1,
      CLS_LF    = 3'd2,
      CLS_DASH  = 3'd3,
      CLS_ALNUM = 3'd4,
      CLS_OTHER = 3'd5
   } class_type;

   typedef enum logic [2:0] {
      PH_WAIT    = 3'b001,
      PH_COLLECT = 3'b010,
      PH_SKIP    = 3'b100
   } phase_type;

   typedef struct packed {
      logic [7:0] text_byte;
      class_type  cls;
   } item_type;

   typedef logic [KwMax*8-1:0] kw_text_type;

   // right-aligned: the last character sits in bits [7:0]
   localparam kw_text_type KW_TEXT [KwCount] = '{
      kw_text_type'("bs"),
      kw_text_type'("c"),
      kw_text_type'("cd"),
      kw_text_type'("dbg"),
      kw_text_type'("f"),
      kw_text_type'("fast"),
      kw_text_type'("p"),
      kw_text_type'("r"),
      kw_text_type'("rst-interval"),
      kw_text_type'("rst-timeout"),
      kw_text_type'("rst"),
      kw_text_type'("stripe"),
      kw_text_type'("sbs"),
      kw_text_type'("striped-block-size"),
      kw_text_type'("tcp-bs"),
      kw_text_type'("vb")
   };

   localparam logic [PosWidth-1:0] KW_LEN [KwCount] = '{
      5'd2, 5'd1, 5'd2, 5'd3, 5'd1, 5'd4, 5'd1, 5'd1,
      5'd12, 5'd11, 5'd3, 5'd6, 5'd3, 5'd18, 5'd6, 5'd2
   };

   localparam logic [3:0] KW_BIT [KwCount] = '{
      4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
      4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd12, 4'd13, 4'd14
   };

endpackage

/* rtl/oks_front.sv */
// Front stage: accepts bytes and registers them with their class.
module oks_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  logic [7:0]        req_text_byte,
   output logic              q_push,
   output oks_pkg::item_type q_item,
   input  logic              q_full
);

   logic                 fr_valid_ff, fr_valid_in;
   oks_pkg::item_type    fr_item_ff;
   oks_pkg::class_type   cls;
   logic                 accept;

   always_comb begin
      case (req_text_byte) inside
         ["0":"9"], ["A":"Z"], ["a":"z"]: cls = oks_pkg::CLS_ALNUM;
         8'h00:                          cls = oks_pkg::CLS_NUL;
         8'h09, 8'h20:                   cls = oks_pkg::CLS_BLANK;
         8'h0a:                          cls = oks_pkg::CLS_LF;
         8'h2d:                          cls = oks_pkg::CLS_DASH;
         default:                        cls = oks_pkg::CLS_OTHER;
      endcase
   end

   assign req_full = fr_valid_ff & q_full;
   assign accept   = req_push & ~req_full;
   assign q_push   = fr_valid_ff & ~q_full;
   assign q_item   = fr_item_ff;

   always_comb begin
      fr_valid_in = fr_valid_ff;
      if (accept) begin
         fr_valid_in = 1'b1;
      end else if (q_push) begin
         fr_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fr_valid_ff <= 1'b0;
      end else begin
         fr_valid_ff <= fr_valid_in;
      end
      if (accept) begin
         fr_item_ff.text_byte <= req_text_byte;
         fr_item_ff.cls       <= cls;
      end
   end

endmodule

/* rtl/oks_queue.sv */
// Small item queue between the front and the back stage.
module oks_queue #(
   parameter int DEPTH = oks_pkg::QueueDepth
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_valid,
   input  oks_pkg::item_type wr_item,
   output logic              full,
   input  logic              rd_take,
   output oks_pkg::item_type rd_item,
   output logic              empty
);

   localparam int PtrWidth = $clog2(DEPTH);
   localparam int CntWidth = $clog2(DEPTH + 1);

   oks_pkg::item_type     mem_ff [DEPTH];
   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0]   count_ff, count_in;
   logic                  do_wr, do_rd;

   assign full    = (count_ff == CntWidth'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_wr   = wr_valid & ~full;
   assign do_rd   = rd_take & ~empty;
   assign rd_item = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PtrWidth'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PtrWidth'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (!do_wr && do_rd) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_item;
      end
   end

endmodule

/* rtl/oks_back.sv */
// Back stage: line machine, keyword match flags and the result register.
module oks_back (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            q_empty,
   input  oks_pkg::item_type               q_item,
   output logic                            q_take,
   output logic                            rsp_empty,
   input  logic                            rsp_pop,
   output logic [oks_pkg::MaskWidth-1:0]   rsp_capability_mask
);

   localparam logic [oks_pkg::PosWidth-1:0] PosMax = '1;

   oks_pkg::phase_type                 phase_ff, phase_in;
   logic [oks_pkg::PosWidth-1:0]       pos_ff, pos_in;
   logic [oks_pkg::KwCount-1:0]        alive_ff, alive_in;
   logic [oks_pkg::MaskWidth-1:0]      cap_ff, cap_in;
   logic                               out_valid_ff, out_valid_in;
   logic [oks_pkg::MaskWidth-1:0]      out_mask_ff;
   logic [oks_pkg::MaskWidth-1:0]      finish_bits;
   logic [oks_pkg::KwCount-1:0]        char_ok;
   logic [oks_pkg::PosWidth-1:0]       shift [oks_pkg::KwCount];
   logic                               is_nul;

   assign is_nul              = (q_item.cls == oks_pkg::CLS_NUL);
   assign q_take              = ~q_empty & (~is_nul | ~out_valid_ff | rsp_pop);
   assign rsp_empty           = ~out_valid_ff;
   assign rsp_capability_mask = out_mask_ff;

   always_comb begin
      finish_bits = '0;
      for (int k = 0; k < oks_pkg::KwCount; k++) begin
         shift[k]   = oks_pkg::KW_LEN[k] - 5'd1 - pos_ff;
         char_ok[k] = (pos_ff < oks_pkg::KW_LEN[k]) &&
                      (8'(oks_pkg::KW_TEXT[k] >> {shift[k], 3'b000}) == q_item.text_byte);
         if (alive_ff[k] && pos_ff == oks_pkg::KW_LEN[k]) begin
            finish_bits[oks_pkg::KW_BIT[k]] = 1'b1;
         end
      end
   end

   always_comb begin
      phase_in     = phase_ff;
      pos_in       = pos_ff;
      alive_in     = alive_ff;
      cap_in       = cap_ff;
      out_valid_in = out_valid_ff & ~rsp_pop;
      if (q_take) begin
         if (is_nul) begin
            out_valid_in = 1'b1;
            phase_in     = oks_pkg::PH_WAIT;
            pos_in       = '0;
            alive_in     = '0;
            cap_in       = '0;
         end else begin
            case (phase_ff)
               oks_pkg::PH_WAIT: begin
                  if (q_item.cls == oks_pkg::CLS_DASH) begin
                     phase_in = oks_pkg::PH_COLLECT;
                     pos_in   = '0;
                     alive_in = '1;
                  end else if (q_item.cls == oks_pkg::CLS_ALNUM ||
                               q_item.cls == oks_pkg::CLS_OTHER) begin
                     phase_in = oks_pkg::PH_SKIP;
                  end
               end
               oks_pkg::PH_COLLECT: begin
                  if (q_item.cls == oks_pkg::CLS_DASH || q_item.cls == oks_pkg::CLS_ALNUM) begin
                     alive_in = alive_ff & char_ok;
                     if (pos_ff != PosMax) begin
                        pos_in = pos_ff + 1'b1;
                     end
                  end else begin
                     cap_in   = cap_ff | finish_bits;
                     alive_in = '0;
                     pos_in   = '0;
                     phase_in = (q_item.cls == oks_pkg::CLS_LF) ? oks_pkg::PH_WAIT
                                                                : oks_pkg::PH_SKIP;
                  end
               end
               default: begin
                  phase_in = (q_item.cls == oks_pkg::CLS_LF) ? oks_pkg::PH_WAIT
                                                             : oks_pkg::PH_SKIP;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= oks_pkg::PH_WAIT;
         pos_ff       <= '0;
         alive_ff     <= '0;
         cap_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         pos_ff       <= pos_in;
         alive_ff     <= alive_in;
         cap_ff       <= cap_in;
         out_valid_ff <= out_valid_in;
      end
      if (q_take && is_nul) begin
         out_mask_ff <= cap_ff | ((phase_ff == oks_pkg::PH_COLLECT) ? finish_bits : '0);
      end
   end

endmodule

/* rtl/option_keyword_scanner.sv */
// Top level of the option keyword scanner: front stage, item queue, back stage.
// A NUL byte accepted passes the front register and the queue before the back
// stage registers its mask. Throughput: one byte per cycle, set by the
// single-byte back stage update, unless a full queue or unpopped result stalls.
// Reset: synchronous, active high; clears valid flags and state, not the mask.
module option_keyword_scanner #(
   parameter int QUEUE_DEPTH = oks_pkg::QueueDepth
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_push,
   output logic                           req_full,
   input  logic [7:0]                     req_text_byte,
   output logic                           rsp_empty,
   input  logic                           rsp_pop,
   output logic [oks_pkg::MaskWidth-1:0]  rsp_capability_mask
);

   logic              q_push, q_full, q_take, q_empty;
   oks_pkg::item_type q_wr_item, q_rd_item;

   oks_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_text_byte (req_text_byte),
      .q_push        (q_push),
      .q_item        (q_wr_item),
      .q_full        (q_full)
   );

   oks_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (q_push),
      .wr_item  (q_wr_item),
      .full     (q_full),
      .rd_take  (q_take),
      .rd_item  (q_rd_item),
      .empty    (q_empty)
   );

   oks_back u_back (
      .clock               (clock),
      .reset               (reset),
      .q_empty             (q_empty),
      .q_item              (q_rd_item),
      .q_take              (q_take),
      .rsp_empty           (rsp_empty),
      .rsp_pop             (rsp_pop),
      .rsp_capability_mask (rsp_capability_mask)
   );

endmodule

/* rtl/oks_checker.sv */
// Port-level checks of the option keyword scanner and their binding.
module oks_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_push,
   input logic                           req_full,
   input logic                           rsp_empty,
   input logic                           rsp_pop,
   input logic [oks_pkg::MaskWidth-1:0]  rsp_capability_mask
);

   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result visible right after reset");

   a_reset_not_full: assert property (@(posedge clock) reset |=> !req_full)
      else $error("input full right after reset");

   a_full_after_accept: assert property (@(posedge clock) disable iff (reset)
      $rose(req_full) |-> $past(req_push && !req_full))
      else $error("input went full without an accepted item");

   a_result_holds: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_capability_mask)))
      else $error("waiting result changed or vanished");

endmodule

bind option_keyword_scanner oks_checker u_oks_checker (
   .clock               (clock),
   .reset               (reset),
   .req_push            (req_push),
   .req_full            (req_full),
   .rsp_empty           (rsp_empty),
   .rsp_pop             (rsp_pop),
   .rsp_capability_mask (rsp_capability_mask)
);
